// ===== sv/ncb_pkg.sv =====
// Shared types, constants and a helper function for the neighbor contrast beta block.
package ncb_pkg;

    localparam int MAX_WIDTH_DEFAULT = 2048;
    localparam int HEIGHT_CAP        = 2048;

    localparam int CFG_W      = 12;
    localparam int COLOR_W    = 8;
    localparam int PIXEL_W    = 3 * COLOR_W;
    localparam int DIST_W     = 18;
    localparam int STEP_SUM_W = 20;
    localparam int STEP_CNT_W = 3;
    localparam int ROW_W      = 11;
    localparam int SUM_W      = 56;
    localparam int COUNT_W    = 40;
    localparam int BETA_W     = 64;
    localparam int FRAC_BITS  = 31;
    localparam int DIVIDEND_W = COUNT_W + FRAC_BITS;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic
    {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_index_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_DIST,
        S_ACCUM,
        S_LAUNCH,
        S_DIVIDE,
        S_EMIT
    } state_t;

    typedef struct packed
    {
        logic [COLOR_W-1:0] pixel_red;
        logic [COLOR_W-1:0] pixel_green;
        logic [COLOR_W-1:0] pixel_blue;
        logic               final_pixel;
    } pixel_word_t;

    typedef struct packed
    {
        logic [BETA_W-1:0]  beta_value;
        logic [SUM_W-1:0]   diff_sum;
        logic [COUNT_W-1:0] pair_count;
        logic               saturated;
    } result_word_t;

    typedef struct packed
    {
        logic accept;
        logic dist_en;
        logic accum_en;
        logic div_start;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed
    {
        logic final_flag;
        logic div_busy;
        logic out_free;
    } ctrl_status_t;

    // squared RGB distance of two packed pixels
    function automatic logic [DIST_W-1:0] color_dist2(
        input logic [PIXEL_W-1:0] a,
        input logic [PIXEL_W-1:0] b
    );
        logic signed [COLOR_W:0]     d;
        logic        [2*COLOR_W-1:0] sq;
        logic        [DIST_W-1:0]    acc;
        acc = '0;
        for (int c = 0; c < 3; c++)
        begin
            d   = $signed({1'b0, a[c*COLOR_W +: COLOR_W]})
                - $signed({1'b0, b[c*COLOR_W +: COLOR_W]});
            sq  = (2*COLOR_W)'(d * d);
            acc = acc + DIST_W'(sq);
        end
        return acc;
    endfunction

endpackage

// ===== sv/ncb_divider.sv =====
// Restoring bit-serial divider producing the Q32.32 beta quotient and an overflow flag.
module ncb_divider
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [ncb_pkg::COUNT_W-1:0]       count,
    input  logic [ncb_pkg::SUM_W-1:0]         divisor,
    output logic                              busy,
    output logic [ncb_pkg::BETA_W-1:0]        quotient,
    output logic                              overflow
);

    logic [ncb_pkg::DIVIDEND_W-1:0] dvd_reg;
    logic [ncb_pkg::SUM_W-1:0]      div_reg;
    logic [ncb_pkg::SUM_W-1:0]      rem_reg;
    logic [ncb_pkg::BETA_W-1:0]     quo_reg;
    logic                           ovf_reg;
    logic [ncb_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic                           busy_reg;

    logic [ncb_pkg::SUM_W:0]        rem_shift;
    logic                           fits;
    logic [ncb_pkg::SUM_W:0]        rem_diff;

    always_comb
    begin
        rem_shift = {rem_reg, dvd_reg[ncb_pkg::DIVIDEND_W-1]};
        fits      = rem_shift >= {1'b0, div_reg};
        rem_diff  = rem_shift - {1'b0, div_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= ncb_pkg::DIV_CNT_W'(ncb_pkg::DIVIDEND_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == ncb_pkg::DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= {count, {ncb_pkg::FRAC_BITS{1'b0}}};
            div_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[ncb_pkg::DIVIDEND_W-2:0], 1'b0};
            rem_reg <= fits ? rem_diff[ncb_pkg::SUM_W-1:0] : rem_shift[ncb_pkg::SUM_W-1:0];
            // a one pushed past bit 63 means beta does not fit
            ovf_reg <= ovf_reg | quo_reg[ncb_pkg::BETA_W-1];
            quo_reg <= {quo_reg[ncb_pkg::BETA_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;
    assign overflow = ovf_reg;

endmodule

// ===== sv/ncb_datapath.sv =====
// Position tracking, line store, pair accumulation, divider and result register.
module ncb_datapath
#(
    parameter int MAX_WIDTH = ncb_pkg::MAX_WIDTH_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ncb_pkg::CFG_W-1:0]     frame_width,
    input  logic [ncb_pkg::CFG_W-1:0]     frame_height,
    input  ncb_pkg::pixel_word_t          pixel,
    input  ncb_pkg::ctrl_cmd_t            cmd,
    output ncb_pkg::ctrl_status_t         status,
    input  logic                          result_ready,
    output logic                          result_valid,
    output ncb_pkg::result_word_t         result
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = (WW > ncb_pkg::CFG_W) ? WW : ncb_pkg::CFG_W;
    localparam int HW    = ncb_pkg::CFG_W;
    localparam int RW    = ncb_pkg::ROW_W;
    localparam int PW    = ncb_pkg::PIXEL_W;

    // line store, previous row of the frame
    logic [PW-1:0] row_mem [MAX_WIDTH];

    logic [CW-1:0]                 col_reg, col_next;
    logic [RW-1:0]                 row_reg, row_next;
    logic [PW-1:0]                 left_reg, upleft_reg;
    logic [ncb_pkg::SUM_W-1:0]     sum_reg;
    logic [ncb_pkg::COUNT_W-1:0]   count_reg;
    logic                          sticky_reg;
    logic                          out_valid_reg, out_valid_next;

    logic [PW-1:0]                 cur_reg, above_reg, upright_reg;
    logic                          has_left_reg, has_up_reg, has_ur_reg, final_reg;
    logic [ncb_pkg::STEP_SUM_W-1:0] step_sum_reg;
    logic [ncb_pkg::STEP_CNT_W-1:0] step_cnt_reg;
    logic [ncb_pkg::SUM_W-1:0]     sum_snap_reg;
    logic [ncb_pkg::COUNT_W-1:0]   count_snap_reg;
    logic                          sticky_snap_reg;
    ncb_pkg::result_word_t         result_reg;

    logic [CMP_W-1:0] w_cfg, w_clip;
    logic [WW-1:0]    eff_w;
    logic [HW-1:0]    eff_h;
    logic             col_wrap;
    logic [CW-1:0]    x;
    logic [HW-1:0]    row_inc, y_inc;
    logic [RW-1:0]    y, row_after;
    logic [WW-1:0]    xp1;
    logic             at_row_end, upright_ok;
    logic [CW-1:0]    addr_b;
    logic [PW-1:0]    cur;

    logic [ncb_pkg::DIST_W-1:0]     d_left, d_upleft, d_up, d_ur;
    logic [ncb_pkg::STEP_SUM_W-1:0] step_sum;
    logic [ncb_pkg::STEP_CNT_W-1:0] step_cnt;
    logic [ncb_pkg::SUM_W:0]        sum_wide;
    logic [ncb_pkg::COUNT_W:0]      count_wide;
    logic                           sum_over, count_over;

    logic                           div_busy, div_ovf;
    logic [ncb_pkg::BETA_W-1:0]     div_quo;
    logic [ncb_pkg::BETA_W-1:0]     beta;
    logic                           sat;

    // effective geometry and the position of the incoming pixel
    always_comb
    begin
        w_cfg  = CMP_W'(frame_width);
        w_clip = (w_cfg > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : w_cfg;
        eff_w  = (w_cfg == '0) ? WW'(1) : w_clip[WW-1:0];
        eff_h  = (frame_height == '0) ? HW'(1)
               : ((frame_height > HW'(ncb_pkg::HEIGHT_CAP)) ? HW'(ncb_pkg::HEIGHT_CAP)
                                                            : frame_height);

        col_wrap   = WW'(col_reg) >= eff_w;
        x          = col_wrap ? '0 : col_reg;
        row_inc    = col_wrap ? HW'(row_reg) + HW'(1) : HW'(row_reg);
        y          = (row_inc >= eff_h) ? '0 : row_inc[RW-1:0];
        xp1        = WW'(x) + WW'(1);
        at_row_end = xp1 >= eff_w;
        y_inc      = HW'(y) + HW'(1);
        row_after  = (y_inc >= eff_h) ? '0 : y_inc[RW-1:0];
        upright_ok = (y != '0) && !at_row_end;
        addr_b     = upright_ok ? xp1[CW-1:0] : x;
        cur        = {pixel.pixel_red, pixel.pixel_green, pixel.pixel_blue};

        col_next = col_reg;
        row_next = row_reg;
        if (cmd.accept)
        begin
            if (pixel.final_pixel)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (at_row_end)
            begin
                col_next = '0;
                row_next = row_after;
            end
            else
            begin
                col_next = xp1[CW-1:0];
                row_next = y;
            end
        end
    end

    // line store: read the old row at both columns, write the new pixel
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            above_reg    <= row_mem[x];
            upright_reg  <= row_mem[addr_b];
            row_mem[x]   <= cur;
            cur_reg      <= cur;
            has_left_reg <= x != '0;
            has_up_reg   <= y != '0;
            has_ur_reg   <= upright_ok;
            final_reg    <= pixel.final_pixel;
        end
    end

    always_comb
    begin
        d_left   = has_left_reg ? ncb_pkg::color_dist2(cur_reg, left_reg) : '0;
        d_upleft = (has_left_reg && has_up_reg) ? ncb_pkg::color_dist2(cur_reg, upleft_reg)
                                                : '0;
        d_up     = has_up_reg ? ncb_pkg::color_dist2(cur_reg, above_reg) : '0;
        d_ur     = has_ur_reg ? ncb_pkg::color_dist2(cur_reg, upright_reg) : '0;
        step_sum = ncb_pkg::STEP_SUM_W'(d_left) + ncb_pkg::STEP_SUM_W'(d_upleft)
                 + ncb_pkg::STEP_SUM_W'(d_up) + ncb_pkg::STEP_SUM_W'(d_ur);
        step_cnt = ncb_pkg::STEP_CNT_W'(has_left_reg)
                 + ncb_pkg::STEP_CNT_W'(has_left_reg && has_up_reg)
                 + ncb_pkg::STEP_CNT_W'(has_up_reg)
                 + ncb_pkg::STEP_CNT_W'(has_ur_reg);
        sum_wide   = {1'b0, sum_reg} + (ncb_pkg::SUM_W + 1)'(step_sum_reg);
        count_wide = {1'b0, count_reg} + (ncb_pkg::COUNT_W + 1)'(step_cnt_reg);
        sum_over   = sum_wide > (ncb_pkg::SUM_W + 1)'(ncb_pkg::SUM_MAX);
        count_over = count_wide > (ncb_pkg::COUNT_W + 1)'(ncb_pkg::COUNT_MAX);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.dist_en)
        begin
            step_sum_reg <= step_sum;
            step_cnt_reg <= step_cnt;
        end
        if (cmd.div_start)
        begin
            sum_snap_reg    <= sum_reg;
            count_snap_reg  <= count_reg;
            sticky_snap_reg <= sticky_reg;
        end
        if (cmd.load_out)
        begin
            result_reg <= '{beta_value: beta, diff_sum: sum_snap_reg,
                            pair_count: count_snap_reg, saturated: sat};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            left_reg      <= '0;
            upleft_reg    <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            sticky_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
            if (cmd.dist_en)
            begin
                left_reg   <= cur_reg;
                upleft_reg <= above_reg;
            end
            if (cmd.accum_en)
            begin
                // saturate each total; the sticky bit remembers the clip
                sum_reg    <= sum_over ? ncb_pkg::SUM_MAX : sum_wide[ncb_pkg::SUM_W-1:0];
                count_reg  <= count_over ? ncb_pkg::COUNT_MAX
                                         : count_wide[ncb_pkg::COUNT_W-1:0];
                sticky_reg <= sticky_reg | sum_over | count_over;
            end
            else if (cmd.div_start)
            begin
                sum_reg    <= '0;
                count_reg  <= '0;
                sticky_reg <= 1'b0;
            end
        end
    end

    ncb_divider u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .count    (count_reg),
        .divisor  (sum_reg),
        .busy     (div_busy),
        .quotient (div_quo),
        .overflow (div_ovf)
    );

    always_comb
    begin
        beta = (sum_snap_reg == '0) ? '0 : (div_ovf ? '1 : div_quo);
        sat  = sticky_snap_reg | ((sum_snap_reg != '0) & div_ovf);
        out_valid_next = cmd.load_out ? 1'b1 : (result_ready ? 1'b0 : out_valid_reg);
    end

    assign status.final_flag = final_reg;
    assign status.div_busy   = div_busy;
    assign status.out_free   = !out_valid_reg || result_ready;
    assign result_valid      = out_valid_reg;
    assign result            = result_reg;

endmodule

// ===== sv/ncb_ctrl.sv =====
// Sequencing state machine: pixel intake, accumulation steps, divide and result load.
module ncb_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pixel_valid,
    output logic                  pixel_ready,
    input  ncb_pkg::ctrl_status_t status,
    output ncb_pkg::ctrl_cmd_t    cmd
);

    ncb_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ncb_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ncb_pkg::S_IDLE:
            begin
                if (pixel_valid)
                begin
                    state_next = ncb_pkg::S_DIST;
                end
            end
            ncb_pkg::S_DIST:
            begin
                state_next = ncb_pkg::S_ACCUM;
            end
            ncb_pkg::S_ACCUM:
            begin
                state_next = status.final_flag ? ncb_pkg::S_LAUNCH : ncb_pkg::S_IDLE;
            end
            ncb_pkg::S_LAUNCH:
            begin
                state_next = ncb_pkg::S_DIVIDE;
            end
            ncb_pkg::S_DIVIDE:
            begin
                if (!status.div_busy)
                begin
                    state_next = ncb_pkg::S_EMIT;
                end
            end
            ncb_pkg::S_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = ncb_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ncb_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pixel_ready   = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            ncb_pkg::S_IDLE:
            begin
                pixel_ready = 1'b1;
                cmd.accept  = pixel_valid;
            end
            ncb_pkg::S_DIST:
            begin
                cmd.dist_en = 1'b1;
            end
            ncb_pkg::S_ACCUM:
            begin
                cmd.accum_en = 1'b1;
            end
            ncb_pkg::S_LAUNCH:
            begin
                cmd.div_start = 1'b1;
            end
            ncb_pkg::S_DIVIDE:
            begin
                cmd = '0;
            end
            ncb_pkg::S_EMIT:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== sv/neighbor_contrast_beta.sv =====
// Top level of the neighbor contrast beta estimator with its register port.
//
// Usage:
//   Pixels enter on the pixel channel (pixel_valid/pixel_ready, one word per
//   pixel) in raster order, frame after frame, all frames frame_width by
//   frame_height. Each pixel adds the squared RGB distances to its left,
//   upper-left, upper and upper-right neighbors inside the frame, and counts
//   those pairs. The word flagged final_pixel closes the set: one result word
//   leaves on the result channel with beta = count / (2 * sum) in Q32.32, the
//   raw sum and count and a saturation flag; then the totals and the raster
//   position restart.
//   Each pixel passes intake, distance and accumulate steps before the next
//   pixel is taken; a closing pixel then launches the bit-serial divider,
//   which forms one quotient bit per cycle over the 71-bit dividend.
//   The line store is one memory with two registered read ports.
//   Reset clears position, totals and the result slot; the frame registers
//   return to 640 by 480; the line store is not cleared and needs no pass.
//   A stalled receiver holds the result word in its slot while pixels keep
//   flowing; only the next closing pixel waits for the slot to empty.
//   Registers: frame_width at byte 0, frame_height at byte 4, 12 bits each.
module neighbor_contrast_beta
#(
    parameter int MAX_WIDTH = ncb_pkg::MAX_WIDTH_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pixel_valid,
    output logic                          pixel_ready,
    input  ncb_pkg::pixel_word_t          pixel,
    output logic                          result_valid,
    input  logic                          result_ready,
    output ncb_pkg::result_word_t         result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ncb_pkg::ADDR_W-1:0]    paddr,
    input  logic [ncb_pkg::DATA_W-1:0]    pwdata,
    output logic [ncb_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    logic [ncb_pkg::CFG_W-1:0] width_reg, width_next;
    logic [ncb_pkg::CFG_W-1:0] height_reg, height_next;
    logic                      cfg_write;
    ncb_pkg::reg_index_t       reg_sel;

    ncb_pkg::ctrl_cmd_t        cmd;
    ncb_pkg::ctrl_status_t     status;

    // register port: no wait states, word select on address bit 2
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign reg_sel   = ncb_pkg::reg_index_t'(paddr[2]);

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        prdata      = '0;
        unique case (reg_sel)
            ncb_pkg::REG_FRAME_WIDTH:
            begin
                prdata = ncb_pkg::DATA_W'(width_reg);
                if (cfg_write)
                begin
                    width_next = pwdata[ncb_pkg::CFG_W-1:0];
                end
            end
            ncb_pkg::REG_FRAME_HEIGHT:
            begin
                prdata = ncb_pkg::DATA_W'(height_reg);
                if (cfg_write)
                begin
                    height_next = pwdata[ncb_pkg::CFG_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= ncb_pkg::WIDTH_RESET;
            height_reg <= ncb_pkg::HEIGHT_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // sequencing
    ncb_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .status      (status),
        .cmd         (cmd)
    );

    // line store, totals, divider and result slot
    ncb_datapath
    #(
        .MAX_WIDTH (MAX_WIDTH)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .pixel        (pixel),
        .cmd          (cmd),
        .status       (status),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ===== sv/ncb_checker.sv =====
// Port-level checks on the neighbor contrast beta block, bound to its top level.
module ncb_checker
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  pixel_valid,
    input logic                  pixel_ready,
    input logic                  result_valid,
    input logic                  result_ready,
    input ncb_pkg::result_word_t result
);

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    // each pixel passes distance and accumulate steps, so intake drops right after a word
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_ready |=> !pixel_ready)
        else $error("pixel taken on consecutive cycles");

    // a zero sum gives a zero beta
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.diff_sum == '0) |-> result.beta_value == '0)
        else $error("nonzero beta with zero sum");

    // no pairs means nothing summed
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.pair_count == '0) |-> result.diff_sum == '0)
        else $error("nonzero sum with zero pair count");

endmodule

bind neighbor_contrast_beta ncb_checker u_checker (.*);
